@@ rtl/rsp_pkg.sv @@
// shared constants, types and gf(256) helpers for the reed-solomon parity encoder
package rsp_pkg;

	localparam int MAX_DEGREE   = 30;
	localparam int MIN_DEGREE   = 7;
	localparam int DEGREE_RESET = 22;
	localparam int CFG_W        = 5;
	localparam int DEG_W        = $clog2(MAX_DEGREE + 1);

	localparam logic [7:0] GF_REDUCE = 8'h1D;
	localparam logic [7:0] GF_ALPHA  = 8'h02;
	localparam logic [7:0] GF_TOPBIT = 8'h80;

	typedef logic [MAX_DEGREE-1:0][7:0] byte_vec_t;

	typedef struct packed {
		logic             busy;
		logic [DEG_W-1:0] degree;
	} gen_stat_t;

	typedef struct packed {
		logic      valid;
		byte_vec_t bytes;
	} par_load_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] z;
		z = '0;
		for (int i = 7; i >= 0; i--) begin
			if ((z & GF_TOPBIT) != 8'd0) begin
				z = (z << 1) ^ GF_REDUCE;
			end else begin
				z = z << 1;
			end
			if (b[i]) begin
				z = z ^ a;
			end
		end
		return z;
	endfunction

	function automatic logic [DEG_W-1:0] eff_degree(input logic [CFG_W-1:0] deg);
		logic [DEG_W-1:0] d;
		if (int'(deg) < MIN_DEGREE) begin
			d = DEG_W'(MIN_DEGREE);
		end else if (int'(deg) > MAX_DEGREE) begin
			d = DEG_W'(MAX_DEGREE);
		end else begin
			d = DEG_W'(deg);
		end
		return d;
	endfunction

endpackage

@@ rtl/rsp_gen.sv @@
// generator polynomial builder, one root multiplied in per cycle
module rsp_gen (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr,
	input  logic [rsp_pkg::CFG_W-1:0] parity_degree,
	output rsp_pkg::byte_vec_t        coeffs,
	output rsp_pkg::gen_stat_t        stat
);

	logic [rsp_pkg::CFG_W-1:0] deg_q;
	logic                      load_q;
	logic [rsp_pkg::DEG_W-1:0] cnt_q;
	logic [7:0]                root_q;
	rsp_pkg::byte_vec_t        coeff_q;
	rsp_pkg::byte_vec_t        coeff_nxt;
	logic [rsp_pkg::DEG_W-1:0] d;
	logic [rsp_pkg::DEG_W-1:0] top_idx;

	assign d       = rsp_pkg::eff_degree(deg_q);
	assign top_idx = d - rsp_pkg::DEG_W'(1);

	always_comb begin
		for (int j = 0; j < rsp_pkg::MAX_DEGREE - 1; j++) begin
			coeff_nxt[j] = rsp_pkg::gf_mul(coeff_q[j], root_q) ^ coeff_q[j+1];
		end
		coeff_nxt[rsp_pkg::MAX_DEGREE-1] =
			rsp_pkg::gf_mul(coeff_q[rsp_pkg::MAX_DEGREE-1], root_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q  <= rsp_pkg::CFG_W'(rsp_pkg::DEGREE_RESET);
			load_q <= 1'b1;
			cnt_q  <= '0;
			root_q <= 8'd1;
		end else if (cfg_wr) begin
			deg_q  <= parity_degree;
			load_q <= 1'b1;
			cnt_q  <= '0;
		end else if (load_q) begin
			load_q <= 1'b0;
			cnt_q  <= d;
			root_q <= 8'd1;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - rsp_pkg::DEG_W'(1);
			root_q <= rsp_pkg::gf_mul(root_q, rsp_pkg::GF_ALPHA);
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			for (int j = 0; j < rsp_pkg::MAX_DEGREE; j++) begin
				coeff_q[j] <= (rsp_pkg::DEG_W'(j) == top_idx) ? 8'd1 : 8'd0;
			end
		end else if (cnt_q != '0) begin
			coeff_q <= coeff_nxt;
		end
	end

	assign coeffs      = coeff_q;
	assign stat.busy   = load_q || (cnt_q != '0);
	assign stat.degree = d;

endmodule

@@ rtl/rsp_lfsr.sv @@
// input register and parallel remainder update, one byte per cycle when not stalled
module rsp_lfsr (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               block_end,
	input  logic               clear,
	input  rsp_pkg::gen_stat_t gen_stat,
	input  rsp_pkg::byte_vec_t coeffs,
	input  logic               load_ok,
	output rsp_pkg::par_load_t load
);

	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               end_s1;
	logic               go;
	logic [7:0]         factor;
	rsp_pkg::byte_vec_t rem_q;
	rsp_pkg::byte_vec_t rem_nxt;

	assign go       = valid_s1 && !gen_stat.busy && (!end_s1 || load_ok);
	assign in_stall = gen_stat.busy || (valid_s1 && !go);
	assign factor   = data_s1 ^ rem_q[0];

	always_comb begin
		for (int j = 0; j < rsp_pkg::MAX_DEGREE - 1; j++) begin
			rem_nxt[j] = rsp_pkg::gf_mul(coeffs[j], factor) ^ rem_q[j+1];
		end
		rem_nxt[rsp_pkg::MAX_DEGREE-1] =
			rsp_pkg::gf_mul(coeffs[rsp_pkg::MAX_DEGREE-1], factor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_q    <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (clear) begin
				rem_q <= '0;
			end else if (go) begin
				rem_q <= end_s1 ? '0 : rem_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			end_s1  <= block_end;
		end
	end

	assign load.valid = go && end_s1;
	assign load.bytes = rem_nxt;

endmodule

@@ rtl/rsp_out.sv @@
// parity shift buffer that sends one parity byte per beat
module rsp_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rsp_pkg::par_load_t        load,
	input  logic [rsp_pkg::DEG_W-1:0] degree,
	output logic                      load_ok,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                parity_byte,
	output logic                      parity_last
);

	rsp_pkg::byte_vec_t        par_q;
	logic [rsp_pkg::DEG_W-1:0] cnt_q;
	logic                      beat;

	assign out_valid   = cnt_q != '0;
	assign beat        = out_valid && !out_stall;
	assign parity_last = cnt_q == rsp_pkg::DEG_W'(1);
	assign parity_byte = par_q[0];
	assign load_ok     = !out_valid || (parity_last && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load.valid) begin
			cnt_q <= degree;
		end else if (beat) begin
			cnt_q <= cnt_q - rsp_pkg::DEG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid) begin
			par_q <= load.bytes;
		end else if (beat) begin
			for (int j = 0; j < rsp_pkg::MAX_DEGREE - 1; j++) begin
				par_q[j] <= par_q[j+1];
			end
		end
	end

endmodule

@@ rtl/reed_solomon_parity_encoder_top.sv @@
// top level of the reed-solomon gf(256) parity encoder
// a byte enters the input register, then updates the remainder; the remainder left by a
//   block's last data byte loads the output shift buffer, which then offers the first parity byte
// throughput: one data byte per cycle when not stalled; a block end waits until the previous block's
//   degree parity bytes (one per beat from the output shift buffer) have drained
// reset and every degree write rebuild the generator, with the input stalled meanwhile
module reed_solomon_parity_encoder_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rsp_pkg::CFG_W-1:0] parity_degree,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                data_byte,
	input  logic                      block_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                parity_byte,
	output logic                      parity_last
);

	rsp_pkg::byte_vec_t coeffs;
	rsp_pkg::gen_stat_t gen_stat;
	rsp_pkg::par_load_t load;
	logic               load_ok;
	logic               cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	rsp_gen u_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.parity_degree (parity_degree),
		.coeffs        (coeffs),
		.stat          (gen_stat)
	);

	rsp_lfsr u_lfsr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.block_end (block_end),
		.clear     (cfg_wr),
		.gen_stat  (gen_stat),
		.coeffs    (coeffs),
		.load_ok   (load_ok),
		.load      (load)
	);

	rsp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.degree      (gen_stat.degree),
		.load_ok     (load_ok),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.parity_byte (parity_byte),
		.parity_last (parity_last)
	);

endmodule

@@ sim/tb_reed_solomon_parity_encoder_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the reed-solomon gf(256) parity encoder top level
module tb_reed_solomon_parity_encoder_top;

	localparam int SETTLE_CYC = 8;
	localparam int HOLD_CYC   = 400;
	localparam int N_PHASES   = 6;
	localparam int PHASE_LEN  = 30;

	typedef enum logic {ROW_BYTE, ROW_DEGREE} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [7:0] val;
		logic       last;
		int         zero_cnt;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] pbyte;
		logic       plast;
	} par_beat_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [rsp_pkg::CFG_W-1:0] parity_degree = rsp_pkg::CFG_W'(rsp_pkg::DEGREE_RESET);
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [7:0]                data_byte = 8'h00;
	logic                      block_end = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [7:0]                parity_byte;
	logic                      parity_last;

	par_beat_t  parity_q[$];
	logic [7:0] rem_bytes [rsp_pkg::MAX_DEGREE];
	logic [7:0] gen_coeffs [rsp_pkg::MAX_DEGREE];
	int         cur_deg;
	int         err_cnt = 0;
	int         rx_beats = 0;
	bit         hold_arm = 1'b0;
	bit         calm_tx = 1'b0;

	// zero bytes give zero parity; saturated degrees typed in directly
	stim_row_t dir_tbl [25] = '{
		'{ROW_BYTE,   8'h00, 1'b1, 22},
		'{ROW_BYTE,   8'hFF, 1'b0, -1},
		'{ROW_BYTE,   8'h80, 1'b0, -1},
		'{ROW_BYTE,   8'h01, 1'b1, -1},
		'{ROW_DEGREE, 8'd7,  1'b0, -1},
		'{ROW_BYTE,   8'h00, 1'b1, 7},
		'{ROW_BYTE,   8'h01, 1'b1, -1},
		'{ROW_BYTE,   8'hFF, 1'b0, -1},
		'{ROW_BYTE,   8'h55, 1'b0, -1},
		'{ROW_BYTE,   8'hAA, 1'b1, -1},
		'{ROW_DEGREE, 8'd0,  1'b0, -1},
		'{ROW_BYTE,   8'h00, 1'b1, 7},
		'{ROW_BYTE,   8'hC3, 1'b1, -1},
		'{ROW_DEGREE, 8'd31, 1'b0, -1},
		'{ROW_BYTE,   8'h00, 1'b1, 30},
		'{ROW_BYTE,   8'hFF, 1'b0, -1},
		'{ROW_BYTE,   8'h12, 1'b1, -1},
		'{ROW_BYTE,   8'h34, 1'b0, -1},
		'{ROW_BYTE,   8'h56, 1'b0, -1},
		'{ROW_DEGREE, 8'd30, 1'b0, -1},
		'{ROW_BYTE,   8'h00, 1'b1, 30},
		'{ROW_DEGREE, 8'd6,  1'b0, -1},
		'{ROW_BYTE,   8'h9A, 1'b0, -1},
		'{ROW_BYTE,   8'hFF, 1'b1, -1},
		'{ROW_DEGREE, 8'd16, 1'b0, -1}
	};

	reed_solomon_parity_encoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.parity_degree (parity_degree),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.block_end     (block_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.parity_byte   (parity_byte),
		.parity_last   (parity_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[7] ? ((x << 1) ^ rsp_pkg::GF_REDUCE) : (x << 1);
		end
		return acc;
	endfunction

	// generator (x - a^0)...(x - a^(d-1)), monic term implied
	task automatic load_degree(input logic [rsp_pkg::CFG_W-1:0] v);
		logic [7:0] root;
		logic [7:0] nv;
		cur_deg = (int'(v) < rsp_pkg::MIN_DEGREE) ? rsp_pkg::MIN_DEGREE :
			(int'(v) > rsp_pkg::MAX_DEGREE) ? rsp_pkg::MAX_DEGREE : int'(v);
		for (int j = 0; j < rsp_pkg::MAX_DEGREE; j++) begin
			gen_coeffs[j] = 8'h00;
			rem_bytes[j] = 8'h00;
		end
		gen_coeffs[cur_deg-1] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < cur_deg; i++) begin
			for (int j = 0; j < cur_deg; j++) begin
				nv = gf_times(gen_coeffs[j], root);
				if (j + 1 < cur_deg) begin
					nv = nv ^ gen_coeffs[j+1];
				end
				gen_coeffs[j] = nv;
			end
			root = gf_times(root, rsp_pkg::GF_ALPHA);
		end
	endtask

	task automatic rs_encode_byte(input logic [7:0] d, input logic e, input bit keep);
		logic [7:0] factor;
		factor = d ^ rem_bytes[0];
		for (int j = 0; j + 1 < cur_deg; j++) begin
			rem_bytes[j] = gf_times(gen_coeffs[j], factor) ^ rem_bytes[j+1];
		end
		rem_bytes[cur_deg-1] = gf_times(gen_coeffs[cur_deg-1], factor);
		if (e) begin
			for (int j = 0; j < cur_deg; j++) begin
				if (keep) begin
					parity_q.push_back('{pbyte: rem_bytes[j], plast: (j + 1 == cur_deg)});
				end
			end
			for (int j = 0; j < rsp_pkg::MAX_DEGREE; j++) begin
				rem_bytes[j] = 8'h00;
			end
		end
	endtask

	function automatic int tx_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_tx || r < 65) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 8'h00;
		end else if (r == 1) begin
			return 8'hFF;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// drives one beat; zero_cnt >= 0 means the parity is typed in as all zero
	task automatic send_byte(input logic [7:0] d, input logic e, input int zero_cnt);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		block_end <= e;
		do @(posedge clk); while (in_stall);
		if (zero_cnt >= 0) begin
			for (int j = 0; j < zero_cnt; j++) begin
				parity_q.push_back('{pbyte: 8'h00, plast: (j + 1 == zero_cnt)});
			end
			rs_encode_byte(d, e, 1'b0);
		end else begin
			rs_encode_byte(d, e, 1'b1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (parity_q.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_degree(input logic [rsp_pkg::CFG_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		parity_degree <= v;
		do @(posedge clk); while (!cfg_ready);
		load_degree(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_beat();
		par_beat_t want;
		if (parity_q.size() == 0) begin
			$error("unexpected beat: parity_byte %02h parity_last %0b", parity_byte,
				parity_last);
			err_cnt++;
		end else begin
			want = parity_q.pop_front();
			if (parity_byte !== want.pbyte) begin
				$error("parity_byte: expected %02h, got %02h", want.pbyte, parity_byte);
				err_cnt++;
			end
			if (parity_last !== want.plast) begin
				$error("parity_last: expected %0b, got %0b", want.plast, parity_last);
				err_cnt++;
			end
		end
	endtask

	initial begin : rx_proc
		int  stall_left;
		int  armed_beats;
		int  r;
		bit  hold_done;
		stall_left = 0;
		armed_beats = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_arm && !hold_done && armed_beats >= 40) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYC;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if ((rx_beats >= 250 && rx_beats < 350) || r < 60) begin
					out_stall <= 1'b0;
				end else if (r < 96) begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(0, 2);
				end else begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(15, 40);
				end
			end
			@(posedge clk);
			if (out_valid && !out_stall) begin
				check_beat();
				rx_beats++;
				if (hold_arm) begin
					armed_beats++;
				end
			end
		end
	end

	initial begin : tx_proc
		int         n;
		int         blen;
		logic [4:0] deg;
		load_degree(rsp_pkg::CFG_W'(rsp_pkg::DEGREE_RESET));
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].kind == ROW_DEGREE) begin
				write_degree(dir_tbl[i].val[rsp_pkg::CFG_W-1:0]);
			end else begin
				send_byte(dir_tbl[i].val, dir_tbl[i].last, dir_tbl[i].zero_cnt);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			deg = (ph == 0) ? 5'd30 : (ph == 1) ? 5'd7 : 5'($urandom_range(0, 31));
			write_degree(deg);
			if (ph == 0) begin
				hold_arm = 1'b1;
			end
			calm_tx = (ph == 2);
			n = 0;
			while (n < PHASE_LEN) begin
				blen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) :
					$urandom_range(1, 10);
				for (int k = 0; k < blen; k++) begin
					send_byte(rand_byte(), (k == blen - 1), -1);
				end
				n += blen;
			end
			// leave a block open so the next degree write lands mid-block
			if ($urandom_range(0, 1) == 1) begin
				blen = $urandom_range(1, 3);
				for (int k = 0; k < blen; k++) begin
					send_byte(rand_byte(), 1'b0, -1);
				end
			end
		end
		calm_tx = 1'b0;
		wait_drained();

		if (err_cnt == 0) begin
			$display("reed_solomon_parity_encoder_top: match");
		end else begin
			$display("reed_solomon_parity_encoder_top: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("reed_solomon_parity_encoder_top: mismatch");
		$finish;
	end

endmodule
